>>> rtl/allm_pkg.sv
// shared types and codes for the array linked list manager
// used by allm_ctrl, allm_dp and array_linked_list_manager; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package allm_pkg;

    localparam int DEF_CAPACITY = 16;
    localparam int VALUE_W      = 32;
    localparam int OP_W         = 3;
    localparam int STATUS_W     = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_INS_HEAD   = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_TAIL   = 3'd1;
    localparam logic [OP_W-1:0] OP_REM_KEY    = 3'd2;
    localparam logic [OP_W-1:0] OP_REM_AFTER  = 3'd3;
    localparam logic [OP_W-1:0] OP_REM_BEFORE = 3'd4;
    localparam logic [OP_W-1:0] OP_DUMP       = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

    // datapath micro-operations
    typedef enum logic [4:0] {
        U_NOP,
        U_ACCEPT,      // latch payload, start pointers at list head
        U_RD_FREE,     // read node at free head
        U_ALLOC,       // pop free node, write its value
        U_LINK_HEAD,   // new node links to list head, becomes head
        U_TAIL_NIL,    // new node links to null
        U_HEAD_NEW,    // new node becomes head
        U_RD_CUR,      // read node at cur
        U_STEP,        // advance walk pointers, count, read next
        U_FIRST,       // advance walk pointers without counting
        U_LINK_TAIL,   // cur links to new node
        U_UNLINK_PREV, // prev skips cur
        U_UNLINK_HEAD, // head skips cur
        U_FREE_CUR,    // push cur on free list
        U_FREE_PREV,   // push prev on free list
        U_FREE_NEW,    // push new on free list
        U_RD_NEXT,     // remember successor of cur and read it
        U_BYPASS,      // cur links past its successor
        U_SLOW_CUR,    // slow links to cur
        U_HEAD_CUR,    // cur becomes head
        U_EMIT,        // status-only result
        U_DUMP         // list value result, step when more follow
    } uop_t;

    typedef struct packed {
        uop_t                uop;
        logic [STATUS_W-1:0] status;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            free_ok;
        logic            head_ok;
        logic            link_ok;
        logic            match;
        logic            cnt_lt;
        logic            prev_ok;
        logic            slow_ok;
        logic            dump_end;
        logic            out_free;
    } stat_t;

endpackage

`default_nettype wire

>>> rtl/allm_dp.sv
// datapath: node store, list pointers, walk registers and result register
// depends on allm_pkg
`timescale 1ns / 1ps
`default_nettype none

module allm_dp #(
    parameter int CAPACITY = allm_pkg::DEF_CAPACITY
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire allm_pkg::cmd_t                        cmd,
    output allm_pkg::stat_t                            stat,
    input  wire logic [allm_pkg::OP_W-1:0]             s_operation,
    input  wire logic signed [allm_pkg::VALUE_W-1:0]   s_value,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic [allm_pkg::STATUS_W-1:0]              m_status,
    output logic signed [allm_pkg::VALUE_W-1:0]        m_item_value,
    output logic                                       m_last
);
    import allm_pkg::*;

    localparam int LW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam logic [LW-1:0] NIL = LW'(CAPACITY);

    // node store
    logic [VALUE_W-1:0] val_mem [CAPACITY];
    logic [LW-1:0]      link_mem [CAPACITY];
    logic [CAPACITY-1:0] link_vld_reg;

    // control state
    logic [LW-1:0] free_head_reg, free_head_next;
    logic [LW-1:0] list_head_reg, list_head_next;
    logic          m_valid_reg, m_valid_next;

    // walk and payload registers
    logic [OP_W-1:0]     op_reg, op_next;
    logic [VALUE_W-1:0]  key_reg, key_next;
    logic [LW-1:0]       cur_reg, cur_next;
    logic [LW-1:0]       prev_reg, prev_next;
    logic [LW-1:0]       slow_reg, slow_next;
    logic [LW-1:0]       new_reg, new_next;
    logic [LW-1:0]       cnt_reg, cnt_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [VALUE_W-1:0]  item_reg, item_next;
    logic                last_reg, last_next;

    // read port
    logic               rd_en;
    logic [LW-1:0]      rd_ptr;
    logic [LW-1:0]      rd_raw_reg;
    logic               rd_vld_reg;
    logic [AW-1:0]      rd_addr_reg;
    logic [VALUE_W-1:0] rd_val_reg;
    logic [LW-1:0]      rd_link;

    // write ports
    logic          lnk_we;
    logic [LW-1:0] lnk_ptr;
    logic [LW-1:0] lnk_data;
    logic          val_we;

    logic link_ok;
    logic dump_end;
    logic out_free;
    logic step;

    // a link entry never written still holds its reset chain value
    assign rd_link  = rd_vld_reg ? rd_raw_reg : LW'(rd_addr_reg) + LW'(1);
    assign link_ok  = (rd_link < NIL);
    assign dump_end = !(link_ok && (cnt_reg < LW'(CAPACITY - 1)));
    assign out_free = !m_valid_reg || m_ready;
    assign step     = (cmd.uop == U_STEP) || (cmd.uop == U_FIRST) ||
                      ((cmd.uop == U_DUMP) && !dump_end);

    always_comb begin
        stat.op       = op_reg;
        stat.free_ok  = (free_head_reg < NIL);
        stat.head_ok  = (list_head_reg < NIL);
        stat.link_ok  = link_ok;
        stat.match    = (rd_val_reg == key_reg);
        stat.cnt_lt   = (cnt_reg < NIL);
        stat.prev_ok  = (prev_reg < NIL);
        stat.slow_ok  = (slow_reg < NIL);
        stat.dump_end = dump_end;
        stat.out_free = out_free;
    end

    // memory port selection
    always_comb begin
        rd_en    = 1'b0;
        rd_ptr   = cur_reg;
        lnk_we   = 1'b0;
        lnk_ptr  = cur_reg;
        lnk_data = free_head_reg;
        val_we   = 1'b0;
        unique case (cmd.uop)
            U_RD_FREE: begin
                rd_en  = 1'b1;
                rd_ptr = free_head_reg;
            end
            U_RD_CUR: begin
                rd_en = 1'b1;
            end
            U_STEP, U_FIRST, U_RD_NEXT: begin
                rd_en  = 1'b1;
                rd_ptr = rd_link;
            end
            U_DUMP: begin
                rd_en  = !dump_end;
                rd_ptr = rd_link;
            end
            U_ALLOC: begin
                val_we = 1'b1;
            end
            U_LINK_HEAD: begin
                lnk_we   = 1'b1;
                lnk_ptr  = new_reg;
                lnk_data = list_head_reg;
            end
            U_TAIL_NIL: begin
                lnk_we   = 1'b1;
                lnk_ptr  = new_reg;
                lnk_data = NIL;
            end
            U_LINK_TAIL: begin
                lnk_we   = 1'b1;
                lnk_data = new_reg;
            end
            U_UNLINK_PREV: begin
                lnk_we   = 1'b1;
                lnk_ptr  = prev_reg;
                lnk_data = rd_link;
            end
            U_FREE_CUR: begin
                lnk_we = 1'b1;
            end
            U_FREE_PREV: begin
                lnk_we  = 1'b1;
                lnk_ptr = prev_reg;
            end
            U_FREE_NEW: begin
                lnk_we  = 1'b1;
                lnk_ptr = new_reg;
            end
            U_BYPASS: begin
                lnk_we   = 1'b1;
                lnk_data = rd_link;
            end
            U_SLOW_CUR: begin
                lnk_we   = 1'b1;
                lnk_ptr  = slow_reg;
                lnk_data = cur_reg;
            end
            default: begin
            end
        endcase
    end

    // register next values
    always_comb begin
        free_head_next = free_head_reg;
        list_head_next = list_head_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        op_next        = op_reg;
        key_next       = key_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        slow_next      = slow_reg;
        new_next       = new_reg;
        cnt_next       = cnt_reg;
        status_next    = status_reg;
        item_next      = item_reg;
        last_next      = last_reg;

        if (step) begin
            slow_next = prev_reg;
            prev_next = cur_reg;
            cur_next  = rd_link;
            if (cmd.uop != U_FIRST) begin
                cnt_next = cnt_reg + LW'(1);
            end
        end

        unique case (cmd.uop)
            U_ACCEPT: begin
                op_next   = s_operation;
                key_next  = s_value;
                cnt_next  = '0;
                prev_next = NIL;
                slow_next = NIL;
                cur_next  = list_head_reg;
            end
            U_ALLOC: begin
                new_next       = free_head_reg;
                free_head_next = rd_link;
            end
            U_LINK_HEAD, U_HEAD_NEW: begin
                list_head_next = new_reg;
            end
            U_RD_NEXT: begin
                new_next = rd_link;
            end
            U_UNLINK_HEAD: begin
                list_head_next = rd_link;
            end
            U_HEAD_CUR: begin
                list_head_next = cur_reg;
            end
            U_FREE_CUR: begin
                free_head_next = cur_reg;
            end
            U_FREE_PREV: begin
                free_head_next = prev_reg;
            end
            U_FREE_NEW: begin
                free_head_next = new_reg;
            end
            U_EMIT: begin
                m_valid_next = 1'b1;
                status_next  = cmd.status;
                item_next    = '0;
                last_next    = 1'b1;
            end
            U_DUMP: begin
                m_valid_next = 1'b1;
                status_next  = ST_DONE;
                item_next    = rd_val_reg;
                last_next    = dump_end;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_head_reg <= '0;
            list_head_reg <= NIL;
            m_valid_reg   <= 1'b0;
            link_vld_reg  <= '0;
        end else begin
            free_head_reg <= free_head_next;
            list_head_reg <= list_head_next;
            m_valid_reg   <= m_valid_next;
            if (lnk_we) begin
                link_vld_reg[lnk_ptr[AW-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        slow_reg   <= slow_next;
        new_reg    <= new_next;
        cnt_reg    <= cnt_next;
        status_reg <= status_next;
        item_reg   <= item_next;
        last_reg   <= last_next;
    end

    // node store: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (lnk_we) begin
            link_mem[lnk_ptr[AW-1:0]] <= lnk_data;
        end
        if (val_we) begin
            val_mem[free_head_reg[AW-1:0]] <= key_reg;
        end
        if (rd_en) begin
            rd_raw_reg  <= link_mem[rd_ptr[AW-1:0]];
            rd_vld_reg  <= link_vld_reg[rd_ptr[AW-1:0]];
            rd_addr_reg <= rd_ptr[AW-1:0];
            rd_val_reg  <= val_mem[rd_ptr[AW-1:0]];
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = status_reg;
    assign m_item_value = item_reg;
    assign m_last       = last_reg;

endmodule

`default_nettype wire

>>> rtl/allm_ctrl.sv
// controller: sequences list operations as datapath micro-operations
// depends on allm_pkg
`timescale 1ns / 1ps
`default_nettype none

module allm_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    output allm_pkg::cmd_t       cmd,
    input  wire allm_pkg::stat_t stat
);
    import allm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_ALLOC,
        S_HEAD,
        S_TAIL,
        S_NEW_HEAD,
        S_TAIL_RD,
        S_TAIL_WALK,
        S_BHEAD,
        S_SEARCH,
        S_BYPASS,
        S_FREE_CUR,
        S_FREE_PREV,
        S_FREE_NEW,
        S_DUMP,
        S_EMIT
    } state_t;

    state_t              state_reg, state_next;
    logic [STATUS_W-1:0] emit_reg, emit_next;

    always_comb begin
        state_next = state_reg;
        emit_next  = emit_reg;
        cmd.uop    = U_NOP;
        cmd.status = emit_reg;
        s_ready    = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.uop    = U_ACCEPT;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                priority if (stat.op == OP_INS_HEAD || stat.op == OP_INS_TAIL) begin
                    if (!stat.free_ok) begin
                        emit_next  = ST_FULL;
                        state_next = S_EMIT;
                    end else begin
                        cmd.uop    = U_RD_FREE;
                        state_next = S_ALLOC;
                    end
                end else if (stat.op == OP_DUMP || stat.op == OP_REM_KEY ||
                             stat.op == OP_REM_AFTER || stat.op == OP_REM_BEFORE) begin
                    if (!stat.head_ok) begin
                        emit_next  = ST_EMPTY;
                        state_next = S_EMIT;
                    end else begin
                        cmd.uop = U_RD_CUR;
                        priority if (stat.op == OP_DUMP) begin
                            state_next = S_DUMP;
                        end else if (stat.op == OP_REM_BEFORE) begin
                            state_next = S_BHEAD;
                        end else begin
                            state_next = S_SEARCH;
                        end
                    end
                end else begin
                    emit_next  = ST_DONE;
                    state_next = S_EMIT;
                end
            end
            S_ALLOC: begin
                cmd.uop    = U_ALLOC;
                state_next = (stat.op == OP_INS_HEAD) ? S_HEAD : S_TAIL;
            end
            S_HEAD: begin
                cmd.uop    = U_LINK_HEAD;
                emit_next  = ST_DONE;
                state_next = S_EMIT;
            end
            S_TAIL: begin
                cmd.uop    = U_TAIL_NIL;
                state_next = stat.head_ok ? S_TAIL_RD : S_NEW_HEAD;
            end
            S_NEW_HEAD: begin
                cmd.uop    = U_HEAD_NEW;
                emit_next  = ST_DONE;
                state_next = S_EMIT;
            end
            S_TAIL_RD: begin
                cmd.uop    = U_RD_CUR;
                state_next = S_TAIL_WALK;
            end
            S_TAIL_WALK: begin
                if (stat.cnt_lt && stat.link_ok) begin
                    cmd.uop = U_STEP;
                end else begin
                    cmd.uop    = U_LINK_TAIL;
                    emit_next  = ST_DONE;
                    state_next = S_EMIT;
                end
            end
            S_BHEAD: begin
                // the head itself has no node before it
                if (!stat.link_ok || stat.match) begin
                    emit_next  = ST_NOT_FOUND;
                    state_next = S_EMIT;
                end else begin
                    cmd.uop    = U_FIRST;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH: begin
                priority if (stat.match) begin
                    priority if (stat.op == OP_REM_KEY) begin
                        cmd.uop    = stat.prev_ok ? U_UNLINK_PREV : U_UNLINK_HEAD;
                        state_next = S_FREE_CUR;
                    end else if (stat.op == OP_REM_AFTER) begin
                        if (stat.link_ok) begin
                            cmd.uop    = U_RD_NEXT;
                            state_next = S_BYPASS;
                        end else begin
                            emit_next  = ST_NOT_FOUND;
                            state_next = S_EMIT;
                        end
                    end else begin
                        cmd.uop    = stat.slow_ok ? U_SLOW_CUR : U_HEAD_CUR;
                        state_next = S_FREE_PREV;
                    end
                end else if (stat.cnt_lt && stat.link_ok) begin
                    cmd.uop = U_STEP;
                end else begin
                    emit_next  = ST_NOT_FOUND;
                    state_next = S_EMIT;
                end
            end
            S_BYPASS: begin
                cmd.uop    = U_BYPASS;
                state_next = S_FREE_NEW;
            end
            S_FREE_CUR: begin
                cmd.uop    = U_FREE_CUR;
                emit_next  = ST_DONE;
                state_next = S_EMIT;
            end
            S_FREE_PREV: begin
                cmd.uop    = U_FREE_PREV;
                emit_next  = ST_DONE;
                state_next = S_EMIT;
            end
            S_FREE_NEW: begin
                cmd.uop    = U_FREE_NEW;
                emit_next  = ST_DONE;
                state_next = S_EMIT;
            end
            S_DUMP: begin
                // one value per cycle while the result register drains
                if (stat.out_free) begin
                    cmd.uop = U_DUMP;
                    if (stat.dump_end) begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.uop    = U_EMIT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            emit_reg  <= ST_DONE;
        end else begin
            state_reg <= state_next;
            emit_reg  <= emit_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/array_linked_list_manager.sv
// top level of the array linked list manager: controller plus datapath
// depends on allm_pkg, allm_ctrl and allm_dp
//
//  channel | ports                                           | direction
//  --------+-------------------------------------------------+----------
//  input   | s_valid s_ready s_operation s_value             | in
//  result  | m_valid m_ready m_status m_item_value m_last    | out
//
// one item at a time; s_ready is high while no item is in progress, even
// when the last result still waits in the output register.
// tail inserts and the removals walk the list one link at a time, up to
// CAPACITY - 1 links, through the single read port of the node store.
// a dump gives one value per cycle while the result is not stalled.
// reset is synchronous and takes effect at once; no clearing pass.
// a stalled result holds the sequencer until m_ready takes it.
`timescale 1ns / 1ps
`default_nettype none

module array_linked_list_manager #(
    parameter int CAPACITY = allm_pkg::DEF_CAPACITY
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [allm_pkg::OP_W-1:0]           s_operation,
    input  wire logic signed [allm_pkg::VALUE_W-1:0] s_value,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [allm_pkg::STATUS_W-1:0]            m_status,
    output logic signed [allm_pkg::VALUE_W-1:0]      m_item_value,
    output logic                                     m_last
);
    import allm_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    allm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    allm_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_operation  (s_operation),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_item_value (m_item_value),
        .m_last       (m_last)
    );

endmodule

`default_nettype wire

>>> tb/tb_array_linked_list_manager.sv
// self-checking testbench for array_linked_list_manager: directed cases, then random traffic
// predicts results with its own node store and free list; depends on allm_pkg and the rtl
`timescale 1ns / 1ps

module tb_array_linked_list_manager;
    import allm_pkg::*;

    localparam int CAP = DEF_CAPACITY;
    localparam logic [4:0] NIL = 5'(CAP);
    localparam int WATCHDOG = 2000;
    localparam int SETTLE = 40;

    // codes the block decodes as no-ops
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef struct {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] item_value;
        logic                      last;
    } list_result_t;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic [OP_W-1:0]           s_operation;
    logic signed [VALUE_W-1:0] s_value;
    logic                      m_valid;
    logic                      m_ready;
    logic [STATUS_W-1:0]       m_status;
    logic signed [VALUE_W-1:0] m_item_value;
    logic                      m_last;

    // shadow copy of the node store
    logic signed [VALUE_W-1:0] node_val [CAP];
    logic [4:0]                node_nxt [CAP];
    logic [4:0]                free_top;
    logic [4:0]                head_ptr;

    list_result_t pending_results[$];
    list_result_t want;
    int errors;
    int idle_pct;
    int stall_pct;
    int quiet_cycles;

    array_linked_list_manager dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_item_value (m_item_value),
        .m_last       (m_last)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    function automatic bit is_node(logic [4:0] p);
        return p < CAP;
    endfunction

    function automatic void push_status(logic [STATUS_W-1:0] st);
        list_result_t r;
        r.status = st;
        r.item_value = '0;
        r.last = 1'b1;
        pending_results.push_back(r);
    endfunction

    function automatic void release_node(logic [4:0] p);
        node_nxt[p] = free_top;
        free_top = p;
    endfunction

    function automatic void clear_lists();
        for (int i = 0; i < CAP; i++) begin
            node_val[i] = '0;
            node_nxt[i] = 5'(i + 1);
        end
        free_top = '0;
        head_ptr = NIL;
    endfunction

    function automatic int list_len();
        logic [4:0] p;
        int n;
        p = head_ptr;
        n = 0;
        while (is_node(p) && n < CAP) begin
            n++;
            p = node_nxt[p];
        end
        return n;
    endfunction

    function automatic logic signed [VALUE_W-1:0] value_at(int idx);
        logic [4:0] p;
        p = head_ptr;
        for (int i = 0; i < idx; i++)
            p = node_nxt[p];
        return node_val[p];
    endfunction

    // update the shadow list for one accepted operation and queue what it emits
    function automatic void apply_list_op(logic [OP_W-1:0] op, logic signed [VALUE_W-1:0] v);
        logic [4:0] x, y, prev, slow;
        int n;
        list_result_t r;
        if (op == OP_INS_HEAD || op == OP_INS_TAIL) begin
            if (!is_node(free_top)) begin
                push_status(ST_FULL);
                return;
            end
            x = free_top;
            free_top = node_nxt[x];
            node_val[x] = v;
            if (op == OP_INS_HEAD) begin
                node_nxt[x] = head_ptr;
                head_ptr = x;
            end else begin
                node_nxt[x] = NIL;
                if (!is_node(head_ptr)) begin
                    head_ptr = x;
                end else begin
                    y = head_ptr;
                    for (n = 0; n < CAP && is_node(node_nxt[y]); n++)
                        y = node_nxt[y];
                    node_nxt[y] = x;
                end
            end
            push_status(ST_DONE);
        end else if (op == OP_DUMP) begin
            if (!is_node(head_ptr)) begin
                push_status(ST_EMPTY);
                return;
            end
            x = head_ptr;
            n = 0;
            while (is_node(x) && n < CAP) begin
                r.status = ST_DONE;
                r.item_value = node_val[x];
                x = node_nxt[x];
                n++;
                r.last = !(is_node(x) && n < CAP);
                pending_results.push_back(r);
            end
        end else if (op > OP_DUMP) begin
            push_status(ST_DONE);
        end else if (!is_node(head_ptr)) begin
            push_status(ST_EMPTY);
        end else if (op == OP_REM_KEY) begin
            x = head_ptr;
            prev = NIL;
            for (n = 0; n < CAP && is_node(x) && node_val[x] != v; n++) begin
                prev = x;
                x = node_nxt[x];
            end
            if (!is_node(x) || node_val[x] != v) begin
                push_status(ST_NOT_FOUND);
                return;
            end
            if (!is_node(prev))
                head_ptr = node_nxt[x];
            else
                node_nxt[prev] = node_nxt[x];
            release_node(x);
            push_status(ST_DONE);
        end else if (op == OP_REM_AFTER) begin
            x = head_ptr;
            for (n = 0; n < CAP && is_node(x) && node_val[x] != v; n++)
                x = node_nxt[x];
            if (!is_node(x) || node_val[x] != v || !is_node(node_nxt[x])) begin
                push_status(ST_NOT_FOUND);
                return;
            end
            y = node_nxt[x];
            node_nxt[x] = node_nxt[y];
            release_node(y);
            push_status(ST_DONE);
        end else begin
            // remove before: the node in front of the key goes back to the free list
            if (!is_node(node_nxt[head_ptr]) || node_val[head_ptr] == v) begin
                push_status(ST_NOT_FOUND);
                return;
            end
            x = node_nxt[head_ptr];
            prev = head_ptr;
            slow = NIL;
            for (n = 0; n < CAP && is_node(x) && node_val[x] != v; n++) begin
                slow = prev;
                prev = x;
                x = node_nxt[x];
            end
            if (!is_node(x) || node_val[x] != v) begin
                push_status(ST_NOT_FOUND);
                return;
            end
            if (!is_node(slow))
                head_ptr = node_nxt[head_ptr];
            else
                node_nxt[slow] = node_nxt[prev];
            release_node(prev);
            push_status(ST_DONE);
        end
    endfunction

    // one transfer on the input channel, with random gaps before it
    task automatic send_op(input logic [OP_W-1:0] op, input logic signed [VALUE_W-1:0] v);
        @(negedge aclk);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_value <= v;
        do
            @(posedge aclk);
        while (!s_ready);
        apply_list_op(op, v);
    endtask

    // hold the input channel until the list has answered everything sent so far
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            return $signed(32'($urandom_range(7)));
        if (r < 50) begin
            case ($urandom_range(3))
                0: return VAL_MAX;
                1: return VAL_MIN;
                2: return '0;
                default: return -32'sd1;
            endcase
        end
        return $signed(32'($urandom));
    endfunction

    // keys mostly come from the list so that removals actually hit
    function automatic logic signed [VALUE_W-1:0] pick_key();
        int len;
        len = list_len();
        if (len > 0 && $urandom_range(99) < 75)
            return value_at($urandom_range(len - 1));
        return pick_value();
    endfunction

    task automatic test_empty_list();
        send_op(OP_DUMP, '0);
        send_op(OP_REM_KEY, 32'sd5);
        send_op(OP_REM_AFTER, 32'sd5);
        send_op(OP_REM_BEFORE, 32'sd5);
        send_op(OP_SPARE_LO, VAL_MAX);
        send_op(OP_SPARE_HI, VAL_MIN);
    endtask

    task automatic test_value_extremes();
        send_op(OP_INS_HEAD, VAL_MAX);
        send_op(OP_INS_TAIL, VAL_MIN);
        send_op(OP_INS_HEAD, '0);
        send_op(OP_INS_TAIL, -32'sd1);
        send_op(OP_DUMP, '0);
    endtask

    // list is 0, max, min, -1 on entry
    task automatic test_removal_cases();
        send_op(OP_REM_AFTER, -32'sd1);
        send_op(OP_REM_BEFORE, '0);
        send_op(OP_REM_KEY, 32'sd1234);
        send_op(OP_REM_AFTER, 32'sd1234);
        send_op(OP_REM_BEFORE, 32'sd1234);
        send_op(OP_REM_BEFORE, VAL_MIN);
        send_op(OP_REM_AFTER, '0);
        send_op(OP_REM_KEY, -32'sd1);
        send_op(OP_DUMP, '0);
        send_op(OP_REM_BEFORE, '0);
        send_op(OP_REM_KEY, '0);
        send_op(OP_DUMP, '0);
    endtask

    // fill past capacity, dump the full list, then send up to 2 * CAP removals to empty it
    task automatic test_full_store();
        for (int i = 0; i < CAP + 2; i++)
            send_op($urandom_range(1) ? OP_INS_TAIL : OP_INS_HEAD, pick_value());
        send_op(OP_DUMP, '0);
        for (int i = 0; i < 2 * CAP && list_len() > 0; i++)
            send_op(3'(OP_REM_KEY + $urandom_range(2)), pick_key());
        send_op(OP_DUMP, '0);
    endtask

    task automatic test_random_traffic(input int items);
        int r, len, ins_pct;
        for (int i = 0; i < items; i++) begin
            if (i == items / 2)
                drain_results();
            len = list_len();
            ins_pct = (len < 4) ? 60 : (len > 12) ? 15 : 35;
            r = $urandom_range(99);
            if (r < 4)
                send_op($urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO, $signed(32'($urandom)));
            else if (r < 4 + ins_pct)
                send_op($urandom_range(1) ? OP_INS_TAIL : OP_INS_HEAD, pick_value());
            else if (r < 90)
                send_op(3'(OP_REM_KEY + $urandom_range(2)), pick_key());
            else
                send_op(OP_DUMP, $signed(32'($urandom)));
        end
    endtask

    always @(negedge aclk)
        m_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: status %0d item_value %0d last %0b",
                       m_status, m_item_value, m_last);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_status);
                    errors++;
                end
                if (m_item_value !== want.item_value) begin
                    $error("item_value: expected %0d, got %0d", want.item_value, m_item_value);
                    errors++;
                end
                if (m_last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, m_last);
                    errors++;
                end
            end
        end
    end

    // ends the run when neither channel moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_operation = '0;
        s_value = '0;
        m_ready = 1'b0;
        errors = 0;
        idle_pct = 0;
        stall_pct = 0;
        quiet_cycles = 0;
        clear_lists();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_list();
        test_value_extremes();
        test_removal_cases();
        test_full_store();

        idle_pct = 0;
        stall_pct = 0;
        test_random_traffic(10);
        idle_pct = 79;
        stall_pct = 0;
        test_random_traffic(10);
        idle_pct = 0;
        stall_pct = 79;
        test_random_traffic(10);
        idle_pct = 15;
        stall_pct = 15;
        test_random_traffic(10);

        drain_results();
        repeat (SETTLE) @(posedge aclk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> files.f
rtl/allm_pkg.sv
rtl/allm_dp.sv
rtl/allm_ctrl.sv
rtl/array_linked_list_manager.sv
tb/tb_array_linked_list_manager.sv
